>>> rtl/jan_pkg.sv
package jan_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int ANGLE_STEPS = 30;
    localparam int CFG_W       = 10;
    localparam int ANGLE_W     = 5;
    localparam int IDX_W       = 3;

    localparam int VAL_W      = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
    localparam int SPAN_W     = VAL_W + 3;
    localparam int GAIN_SHIFT = 9;
    localparam int DIVD_W     = SAMPLE_BITS + GAIN_SHIFT;
    localparam int CNT_W      = $clog2(DIVD_W + 1);

    localparam int SCALE_W   = 10;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = SCALE_W + COEF_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int AXIS_W    = 11;
    localparam int FRAC_BITS = 14;
    localparam int FRAC_MASK = (1 << FRAC_BITS) - 1;
    localparam int MUL_STEPS = 4;
    localparam int MSEL_W    = $clog2(MUL_STEPS);

    localparam int SCALE_MAX     = 511;
    localparam int SCALE_NEG_MAG = 512;

    localparam int S_TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * AXIS_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0]       MARGIN_RESET = CFG_W'(16);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MID   = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));

    typedef enum logic [IDX_W-1:0] {
        REG_DEADZONE,
        REG_EDGE_MARGIN,
        REG_STICK_ON_LEFT,
        REG_ANGLE_LEFT,
        REG_ANGLE_RIGHT,
        REG_INVERT_LEFT,
        REG_INVERT_RIGHT
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SETUP,
        ST_DIV,
        ST_STORE,
        ST_MUL,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              capture;
        logic              recenter;
        logic              widen;
        logic              setup;
        logic              div_step;
        logic              store;
        logic              mul_step;
        logic              finish;
        logic              out_load;
        logic              axis_sel;
        logic [MSEL_W-1:0] mul_sel;
    } jan_cmd_t;

    typedef struct packed {
        logic recenter;
        logic out_free;
    } jan_status_t;

    function automatic logic signed [COEF_W-1:0] cos_q14(input logic [ANGLE_W-1:0] a);
        logic signed [COEF_W-1:0] c;
        case (a)
            5'd0:  c = 16'sd16384;
            5'd1:  c = 16'sd16026;
            5'd2:  c = 16'sd14968;
            5'd3:  c = 16'sd13255;
            5'd4:  c = 16'sd10963;
            5'd5:  c = 16'sd8192;
            5'd6:  c = 16'sd5063;
            5'd7:  c = 16'sd1713;
            5'd8:  c = -16'sd1713;
            5'd9:  c = -16'sd5063;
            5'd10: c = -16'sd8192;
            5'd11: c = -16'sd10963;
            5'd12: c = -16'sd13255;
            5'd13: c = -16'sd14968;
            5'd14: c = -16'sd16026;
            5'd15: c = -16'sd16384;
            5'd16: c = -16'sd16026;
            5'd17: c = -16'sd14968;
            5'd18: c = -16'sd13255;
            5'd19: c = -16'sd10963;
            5'd20: c = -16'sd8192;
            5'd21: c = -16'sd5063;
            5'd22: c = -16'sd1713;
            5'd23: c = 16'sd1713;
            5'd24: c = 16'sd5063;
            5'd25: c = 16'sd8192;
            5'd26: c = 16'sd10963;
            5'd27: c = 16'sd13255;
            5'd28: c = 16'sd14968;
            5'd29: c = 16'sd16026;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] sin_q14(input logic [ANGLE_W-1:0] a);
        logic signed [COEF_W-1:0] s;
        case (a)
            5'd0:  s = 16'sd0;
            5'd1:  s = 16'sd3406;
            5'd2:  s = 16'sd6664;
            5'd3:  s = 16'sd9630;
            5'd4:  s = 16'sd12176;
            5'd5:  s = 16'sd14189;
            5'd6:  s = 16'sd15582;
            5'd7:  s = 16'sd16294;
            5'd8:  s = 16'sd16294;
            5'd9:  s = 16'sd15582;
            5'd10: s = 16'sd14189;
            5'd11: s = 16'sd12176;
            5'd12: s = 16'sd9630;
            5'd13: s = 16'sd6664;
            5'd14: s = 16'sd3406;
            5'd15: s = 16'sd0;
            5'd16: s = -16'sd3406;
            5'd17: s = -16'sd6664;
            5'd18: s = -16'sd9630;
            5'd19: s = -16'sd12176;
            5'd20: s = -16'sd14189;
            5'd21: s = -16'sd15582;
            5'd22: s = -16'sd16294;
            5'd23: s = -16'sd16294;
            5'd24: s = -16'sd15582;
            5'd25: s = -16'sd14189;
            5'd26: s = -16'sd12176;
            5'd27: s = -16'sd9630;
            5'd28: s = -16'sd6664;
            5'd29: s = -16'sd3406;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/joystick_axis_normalizer.sv
// Calibrates and rotates a pair of joystick converter samples. A beat with
// s_tuser low is a sample: each axis widens its tracked min/max, values within
// the deadzone of center give 0, others scale to -512..+511 over the span to the
// tracked extreme less the edge margin, then the pair is rotated by the
// selected multiple of 12 degrees (X optionally negated). A beat with s_tuser
// high recenters on its sample, restores deadzone and edge margin to 16 and
// returns zeros. A new beat is accepted only after the last one has reached
// the output register. The serial restoring divider (19 steps per axis) is
// shared by both axes, and a single multiplier forms the four rotation
// products. One finished result can wait in the output register while the
// next beat is accepted and processed. The user must make configuration
// writes only while the block is idle; the block does not enforce this.
module joystick_axis_normalizer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [jan_pkg::S_TDATA_W-1:0]     s_tdata,   // raw_x, raw_y, zero pad
    input  logic                              s_tuser,   // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [jan_pkg::M_TDATA_W-1:0]     m_tdata,   // axis_x, axis_y, zero pad
    input  logic                              cfg_wr_en,
    input  logic [jan_pkg::IDX_W-1:0]         cfg_addr,
    input  logic [jan_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam int SB = jan_pkg::SAMPLE_BITS;
    localparam int OW = jan_pkg::AXIS_W;

    jan_pkg::jan_cmd_t    cmd;
    jan_pkg::jan_status_t status;
    logic signed [OW-1:0] axis_x, axis_y;

    jan_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    jan_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_recenter (s_tuser),
        .in_raw_x    (s_tdata[SB-1:0]),
        .in_raw_y    (s_tdata[2*SB-1:SB]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_axis_x    (axis_x),
        .m_axis_y    (axis_y)
    );

    assign m_tdata = {{(jan_pkg::M_TDATA_W - 2 * OW){1'b0}}, axis_y, axis_x};

endmodule

>>> rtl/jan_ctrl.sv
module jan_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  jan_pkg::jan_status_t  status,
    output jan_pkg::jan_cmd_t     cmd
);

    jan_pkg::state_t                 state_reg, state_next;
    logic                            axis_reg, axis_next;
    logic [jan_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [jan_pkg::MSEL_W-1:0]      mul_reg, mul_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jan_pkg::ST_IDLE;
            axis_reg  <= 1'b0;
            cnt_reg   <= '0;
            mul_reg   <= '0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            cnt_reg   <= cnt_next;
            mul_reg   <= mul_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        cnt_next     = cnt_reg;
        mul_next     = mul_reg;
        cmd          = '0;
        cmd.axis_sel = axis_reg;
        cmd.mul_sel  = mul_reg;
        s_tready     = 1'b0;
        case (state_reg)
            jan_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = jan_pkg::ST_PREP;
                end
            end
            jan_pkg::ST_PREP: begin
                if (status.recenter) begin
                    cmd.recenter = 1'b1;
                    state_next   = jan_pkg::ST_OUT;
                end else begin
                    cmd.widen  = 1'b1;
                    axis_next  = 1'b0;
                    state_next = jan_pkg::ST_SETUP;
                end
            end
            jan_pkg::ST_SETUP: begin
                cmd.setup  = 1'b1;
                cnt_next   = '0;
                state_next = jan_pkg::ST_DIV;
            end
            jan_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + jan_pkg::CNT_W'(1);
                if (cnt_reg == jan_pkg::CNT_W'(jan_pkg::DIVD_W - 1)) begin
                    state_next = jan_pkg::ST_STORE;
                end
            end
            jan_pkg::ST_STORE: begin
                cmd.store = 1'b1;
                if (!axis_reg) begin
                    axis_next  = 1'b1;
                    state_next = jan_pkg::ST_SETUP;
                end else begin
                    mul_next   = '0;
                    state_next = jan_pkg::ST_MUL;
                end
            end
            jan_pkg::ST_MUL: begin
                cmd.mul_step = 1'b1;
                mul_next     = mul_reg + jan_pkg::MSEL_W'(1);
                if (mul_reg == jan_pkg::MSEL_W'(jan_pkg::MUL_STEPS - 1)) begin
                    state_next = jan_pkg::ST_FINISH;
                end
            end
            jan_pkg::ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = jan_pkg::ST_OUT;
            end
            jan_pkg::ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = jan_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = jan_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/jan_dp.sv
module jan_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  jan_pkg::jan_cmd_t                   cmd,
    output jan_pkg::jan_status_t                status,
    input  logic                                in_recenter,
    input  logic [jan_pkg::SAMPLE_BITS-1:0]     in_raw_x,
    input  logic [jan_pkg::SAMPLE_BITS-1:0]     in_raw_y,
    input  logic                                cfg_wr_en,
    input  logic [jan_pkg::IDX_W-1:0]           cfg_addr,
    input  logic [jan_pkg::CFG_W-1:0]           cfg_wdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic signed [jan_pkg::AXIS_W-1:0]   m_axis_x,
    output logic signed [jan_pkg::AXIS_W-1:0]   m_axis_y
);

    localparam int SB = jan_pkg::SAMPLE_BITS;
    localparam int SW = jan_pkg::SPAN_W;
    localparam int DW = jan_pkg::DIVD_W;
    localparam int QW = jan_pkg::SCALE_W;
    localparam int AW = jan_pkg::ACC_W;
    localparam int OW = jan_pkg::AXIS_W;

    // configuration
    logic [jan_pkg::CFG_W-1:0]   deadzone_reg, edge_margin_reg;
    logic                        stick_on_left_reg, invert_left_reg, invert_right_reg;
    logic [jan_pkg::ANGLE_W-1:0] angle_left_reg, angle_right_reg;

    // calibration state
    logic [SB-1:0] center_x_reg, center_y_reg;
    logic [SB-1:0] low_x_reg, high_x_reg, low_y_reg, high_y_reg;

    // payload
    logic                           recenter_reg;
    logic [SB-1:0]                  raw_x_reg, raw_y_reg;
    logic [SB-1:0]                  rem_reg, divisor_reg;
    logic [DW-1:0]                  quo_reg;
    logic                           neg_reg, zero_reg;
    logic signed [QW-1:0]           scale_x_reg, scale_y_reg;
    logic signed [AW-1:0]           acc_x_reg, acc_y_reg;
    logic signed [OW-1:0]           rx_reg, ry_reg;
    logic signed [OW-1:0]           out_x_reg, out_y_reg;
    logic                           m_tvalid_reg;

    function automatic logic signed [OW-1:0] q14_trunc(input logic signed [AW-1:0] acc);
        logic signed [AW-1:0] adj;
        adj = acc + (acc[AW-1] ? AW'(jan_pkg::FRAC_MASK) : AW'(0));
        return adj[jan_pkg::FRAC_BITS+OW-1:jan_pkg::FRAC_BITS];
    endfunction

    // axis scaling setup
    logic [SB-1:0]        v_sel, c_sel, lo_sel, hi_sel;
    logic signed [SW-1:0] v_s, c_s, lo_s, hi_s, dz_s, em_s, d_s, mag_s, num_s, span_s;
    logic                 pos, below;
    logic [SB-1:0]        num_mag;
    logic [DW-1:0]        dividend;

    always_comb begin
        v_sel   = cmd.axis_sel ? raw_y_reg    : raw_x_reg;
        c_sel   = cmd.axis_sel ? center_y_reg : center_x_reg;
        lo_sel  = cmd.axis_sel ? low_y_reg    : low_x_reg;
        hi_sel  = cmd.axis_sel ? high_y_reg   : high_x_reg;
        v_s     = $signed(SW'(v_sel));
        c_s     = $signed(SW'(c_sel));
        lo_s    = $signed(SW'(lo_sel));
        hi_s    = $signed(SW'(hi_sel));
        dz_s    = $signed(SW'(deadzone_reg));
        em_s    = $signed(SW'(edge_margin_reg));
        d_s     = v_s - c_s;
        pos     = (d_s > 0);
        mag_s   = d_s[SW-1] ? -d_s : d_s;
        below   = (mag_s < dz_s);
        num_s   = mag_s - dz_s;
        span_s  = pos ? (hi_s - em_s - c_s - dz_s) : (c_s - dz_s - lo_s - em_s);
        num_mag = num_s[SB-1:0];
        // times 511 as shift and subtract
        dividend = {num_mag, {jan_pkg::GAIN_SHIFT{1'b0}}} - DW'(num_mag);
    end

    // restoring divide step
    logic [SB:0]   shifted, diff;
    logic          ge;
    logic signed [QW-1:0] scale_q;

    always_comb begin
        shifted = {rem_reg, quo_reg[DW-1]};
        diff    = shifted - {1'b0, divisor_reg};
        ge      = (shifted >= {1'b0, divisor_reg});
        if (zero_reg) begin
            scale_q = '0;
        end else if (neg_reg) begin
            if (quo_reg > DW'(jan_pkg::SCALE_NEG_MAG)) begin
                scale_q = QW'(-jan_pkg::SCALE_NEG_MAG);
            end else begin
                scale_q = -$signed(quo_reg[QW-1:0]);
            end
        end else begin
            if (quo_reg > DW'(jan_pkg::SCALE_MAX)) begin
                scale_q = QW'(jan_pkg::SCALE_MAX);
            end else begin
                scale_q = $signed(quo_reg[QW-1:0]);
            end
        end
    end

    // rotation multiply
    logic [jan_pkg::ANGLE_W-1:0]          a_raw, a_idx;
    logic                                 inv;
    logic signed [QW-1:0]                 mul_a;
    logic signed [jan_pkg::COEF_W-1:0]    mul_b;
    logic signed [jan_pkg::PROD_W-1:0]    prod;
    logic signed [AW-1:0]                 prod_ext;
    logic signed [OW-1:0]                 rx_t, ry_t;

    always_comb begin
        a_raw = stick_on_left_reg ? angle_left_reg : angle_right_reg;
        a_idx = (a_raw >= jan_pkg::ANGLE_W'(jan_pkg::ANGLE_STEPS))
              ? a_raw - jan_pkg::ANGLE_W'(jan_pkg::ANGLE_STEPS) : a_raw;
        inv   = stick_on_left_reg ? invert_left_reg : invert_right_reg;
        // steps: x*cos, y*sin, y*cos, x*sin
        mul_a = (cmd.mul_sel == 2'd0 || cmd.mul_sel == 2'd3) ? scale_x_reg : scale_y_reg;
        mul_b = (cmd.mul_sel == 2'd0 || cmd.mul_sel == 2'd2)
              ? jan_pkg::cos_q14(a_idx) : jan_pkg::sin_q14(a_idx);
        prod     = mul_a * mul_b;
        prod_ext = {prod[jan_pkg::PROD_W-1], prod};
        rx_t     = q14_trunc(acc_x_reg);
        ry_t     = q14_trunc(acc_y_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadzone_reg      <= jan_pkg::MARGIN_RESET;
            edge_margin_reg   <= jan_pkg::MARGIN_RESET;
            stick_on_left_reg <= 1'b1;
            angle_left_reg    <= '0;
            angle_right_reg   <= '0;
            invert_left_reg   <= 1'b0;
            invert_right_reg  <= 1'b0;
            center_x_reg      <= jan_pkg::SAMPLE_MID;
            center_y_reg      <= jan_pkg::SAMPLE_MID;
            low_x_reg         <= jan_pkg::SAMPLE_MID;
            high_x_reg        <= jan_pkg::SAMPLE_MID;
            low_y_reg         <= jan_pkg::SAMPLE_MID;
            high_y_reg        <= jan_pkg::SAMPLE_MID;
        end else begin
            if (cfg_wr_en) begin
                case (jan_pkg::reg_idx_t'(cfg_addr))
                    jan_pkg::REG_DEADZONE:      deadzone_reg      <= cfg_wdata;
                    jan_pkg::REG_EDGE_MARGIN:   edge_margin_reg   <= cfg_wdata;
                    jan_pkg::REG_STICK_ON_LEFT: stick_on_left_reg <= cfg_wdata[0];
                    jan_pkg::REG_ANGLE_LEFT:    angle_left_reg    <= cfg_wdata[jan_pkg::ANGLE_W-1:0];
                    jan_pkg::REG_ANGLE_RIGHT:   angle_right_reg   <= cfg_wdata[jan_pkg::ANGLE_W-1:0];
                    jan_pkg::REG_INVERT_LEFT:   invert_left_reg   <= cfg_wdata[0];
                    jan_pkg::REG_INVERT_RIGHT:  invert_right_reg  <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.recenter) begin
                center_x_reg    <= raw_x_reg;
                low_x_reg       <= raw_x_reg;
                high_x_reg      <= raw_x_reg;
                center_y_reg    <= raw_y_reg;
                low_y_reg       <= raw_y_reg;
                high_y_reg      <= raw_y_reg;
                deadzone_reg    <= jan_pkg::MARGIN_RESET;
                edge_margin_reg <= jan_pkg::MARGIN_RESET;
            end
            if (cmd.widen) begin
                if (raw_x_reg > high_x_reg) begin
                    high_x_reg <= raw_x_reg;
                end else if (raw_x_reg < low_x_reg) begin
                    low_x_reg <= raw_x_reg;
                end
                if (raw_y_reg > high_y_reg) begin
                    high_y_reg <= raw_y_reg;
                end else if (raw_y_reg < low_y_reg) begin
                    low_y_reg <= raw_y_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            recenter_reg <= in_recenter;
            raw_x_reg    <= in_raw_x;
            raw_y_reg    <= in_raw_y;
        end
        if (cmd.setup) begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= span_s[SB-1:0];
            neg_reg     <= !pos;
            zero_reg    <= below || (span_s <= 0);
        end
        if (cmd.div_step) begin
            rem_reg <= ge ? diff[SB-1:0] : shifted[SB-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
        if (cmd.store) begin
            if (cmd.axis_sel) begin
                scale_y_reg <= scale_q;
            end else begin
                scale_x_reg <= scale_q;
            end
        end
        if (cmd.mul_step) begin
            case (cmd.mul_sel)
                2'd0:    acc_x_reg <= prod_ext;
                2'd1:    acc_x_reg <= acc_x_reg + prod_ext;
                2'd2:    acc_y_reg <= prod_ext;
                default: acc_y_reg <= acc_y_reg - prod_ext;
            endcase
        end
        if (cmd.recenter) begin
            rx_reg <= '0;
            ry_reg <= '0;
        end
        if (cmd.finish) begin
            rx_reg <= inv ? -rx_t : rx_t;
            ry_reg <= ry_t;
        end
        if (cmd.out_load) begin
            out_x_reg <= rx_reg;
            out_y_reg <= ry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign status.recenter = recenter_reg;
    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_axis_x        = out_x_reg;
    assign m_axis_y        = out_y_reg;

endmodule
